// ===== rtl/sbeq_pkg.sv =====
// shared widths, register indexes, config and control structs for the tone eq
// rounding helper used by the writeback path of the shared multiplier
// no dependencies
package sbeq_pkg;

    localparam int BANDS      = 6;
    localparam int BAND_W     = 3;
    localparam int SMP_W      = 24;
    localparam int X_W        = 25;
    localparam int MEM_W      = 28;
    localparam int OUT_W      = 32;
    localparam int ACC_W      = 35;
    localparam int OPA_W      = 33;
    localparam int OPB_W      = 28;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int RND_W      = PROD_W + 1;
    localparam int ENV_W      = 25;
    localparam int KNOB_W     = 16;
    localparam int STEP_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KNOB_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd6;

    // unity in q.24
    localparam logic [ENV_W-1:0] ONE_Q24 = 25'd16777216;

    typedef struct packed {
        logic [BANDS-1:0][KNOB_W-1:0] knob;
        logic [BANDS-1:0][KNOB_W-1:0] hp_coef;
        logic [BANDS-1:0][KNOB_W-1:0] lp_coef;
        logic [STEP_W-1:0]            atk_step;
        logic [STEP_W-1:0]            rel_step;
    } t_cfg;

    typedef struct packed {
        logic step_a;
        logic step_b;
    } t_env_ctl;

    // floor((v + 2^(s-1)) / 2^s), round half up
    function automatic logic signed [RND_W-1:0] round_sh(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic signed [RND_W-1:0] w;
        w = RND_W'(v) + (RND_W'(1) <<< (s - 1));
        return w >>> s;
    endfunction

endpackage

// ===== rtl/six_band_tone_eq_with_envelope_core.sv =====
// six-band tone eq with envelope follower, one shared multiplier under a sequencer
// audio item: 24 products on the shared multiplier plus a prep step for each of the 12
//   filter updates; no new item is accepted until the sequencer is back in idle
// zero sample: skips the filters and gives a zero result; detector: two envelope steps, no result
// synchronous active-low reset clears filter memories, envelope, config to defaults
// depends on sbeq_pkg, sbeq_cfg_regs, sbeq_mul, sbeq_env
module six_band_tone_eq_with_envelope_core
    import sbeq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic signed [SMP_W-1:0] i_sample_in,
    // result items
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_sample_out,
    // config writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_WB    = 7'b0001000,
        S_ENV_A = 7'b0010000,
        S_ENV_B = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // micro-ops run on the shared multiplier
    typedef enum logic [2:0] {
        OP_HP,
        OP_LP,
        OP_KSQ,
        OP_KPLB,
        OP_TERM
    } t_op;

    // how a band builds its gain from the knob
    typedef enum logic [1:0] {
        GK_ENV,
        GK_SQ7,
        GK_SQ5,
        GK_LIN
    } t_gain;

    function automatic t_gain gain_kind(input logic [BAND_W-1:0] b);
        case (b)
            3'd0, 3'd2: return GK_ENV;
            3'd1:       return GK_SQ7;
            3'd5:       return GK_SQ5;
            default:    return GK_LIN;
        endcase
    endfunction

    function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [31:0] v);
        if (v > 32'sd134217727) begin
            return 28'sh7FF_FFFF;
        end else if (v < -32'sd134217728) begin
            return 28'sh800_0000;
        end
        return v[MEM_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[OUT_W-1:0];
    endfunction

    localparam logic [BAND_W-1:0]       LAST_BAND = BAND_W'(BANDS - 1);
    localparam logic signed [OPB_W-1:0] HALF_GAIN = 28'sd8388608;

    t_cfg     cfg;
    t_env_ctl env_ctl;
    t_state   r_state, n_state;
    t_op      r_op;

    logic [ENV_W-1:0]         env;
    logic [BAND_W-1:0]        r_band;
    logic signed [X_W-1:0]    r_x;
    logic signed [OPA_W-1:0]  r_opa;
    logic [31:0]              r_ksq;
    logic signed [OPB_W-1:0]  r_gain;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [OUT_W-1:0]  r_out;
    logic                     r_out_valid;

    // filter memories, one high-pass and one low-pass per band
    logic signed [MEM_W-1:0]  r_hp [BANDS];
    logic signed [MEM_W-1:0]  r_lp [BANDS];

    logic                     take;
    logic                     load_out;
    logic signed [MEM_W-1:0]  hp_cur;
    logic signed [MEM_W-1:0]  lp_cur;
    logic [KNOB_W-1:0]        knob_cur;
    logic signed [OPA_W-1:0]  diff_hp;
    logic signed [OPA_W-1:0]  diff_lp;
    logic [26:0]              plb_u;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [RND_W-1:0]  rnd16;
    logic signed [RND_W-1:0]  rnd7;
    logic signed [RND_W-1:0]  rnd5;
    logic signed [RND_W-1:0]  rnd32;
    logic signed [RND_W-1:0]  rnd24;
    logic signed [MEM_W-1:0]  hp_new;
    logic signed [MEM_W-1:0]  lp_new;
    logic signed [OPB_W-1:0]  gain_lin;

    sbeq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbeq_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign env_ctl.step_a = (r_state == S_ENV_A);
    assign env_ctl.step_b = (r_state == S_ENV_B);

    sbeq_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (env_ctl),
        .i_x     (r_x),
        .i_atk   (cfg.atk_step),
        .i_rel   (cfg.rel_step),
        .o_env   (env)
    );

    // config registers take a write in any cycle
    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == S_IDLE);
    assign take         = i_valid && o_ready;
    // result leaves through a register, so the next item may start while it waits
    assign load_out     = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    always_comb begin
        hp_cur   = r_hp[r_band];
        lp_cur   = r_lp[r_band];
        knob_cur = cfg.knob[r_band];

        // operand prep: x - hp for the high-pass, (x - hp) - lp for the low-pass
        diff_hp = OPA_W'(r_x) - OPA_W'(hp_cur);
        diff_lp = diff_hp - OPA_W'(lp_cur);

        // envelope-dependent factor (2 - env) * 2 in q.24
        plb_u = (27'd33554432 - 27'(env)) << 1;

        case (r_op)
            OP_HP: begin
                mul_a = r_opa;
                mul_b = signed'({12'b0, cfg.hp_coef[r_band]});
            end
            OP_LP: begin
                mul_a = r_opa;
                mul_b = signed'({12'b0, cfg.lp_coef[r_band]});
            end
            OP_KSQ: begin
                mul_a = signed'({17'b0, knob_cur});
                mul_b = signed'({12'b0, knob_cur});
            end
            OP_KPLB: begin
                mul_a = signed'({1'b0, r_ksq});
                mul_b = signed'({1'b0, plb_u});
            end
            OP_TERM: begin
                mul_a = OPA_W'(lp_cur);
                mul_b = r_gain;
            end
            default: begin
                mul_a = r_opa;
                mul_b = '0;
            end
        endcase

        // writeback arithmetic on the registered product
        rnd16    = round_sh(prod, 16);
        rnd7     = round_sh(prod, 7);
        rnd5     = round_sh(prod, 5);
        rnd32    = round_sh(prod, 32);
        rnd24    = round_sh(prod, 24);
        hp_new   = sat_mem(32'(hp_cur) + signed'(rnd16[31:0]));
        lp_new   = sat_mem(32'(lp_cur) + signed'(rnd16[31:0]));
        gain_lin = signed'({3'b000, knob_cur, 9'b0});
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_command) begin
                        n_state = S_ENV_A;
                    end else if (i_sample_in == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP:  n_state = S_MUL;
            S_MUL:   n_state = S_WB;
            S_WB: begin
                case (r_op)
                    OP_HP:   n_state = S_PREP;
                    OP_TERM: n_state = (r_band == LAST_BAND) ? S_DONE : S_PREP;
                    default: n_state = S_MUL;
                endcase
            end
            S_ENV_A: n_state = S_ENV_B;
            S_ENV_B: n_state = S_IDLE;
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= sat_out(r_acc);
        end
    end

    // filter memories: cleared by reset, untouched by a zero sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BANDS; k++) begin
                r_hp[k] <= '0;
                r_lp[k] <= '0;
            end
        end else if (r_state == S_WB) begin
            if (r_op == OP_HP) begin
                r_hp[r_band] <= hp_new;
            end
            if (r_op == OP_LP) begin
                r_lp[r_band] <= lp_new;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= '0;
            r_op   <= OP_HP;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_x    <= {i_sample_in, 1'b0};
                        r_acc  <= (i_command || i_sample_in == '0) ? '0 : ACC_W'(i_sample_in);
                        r_band <= '0;
                        r_op   <= OP_HP;
                    end
                end
                S_PREP: begin
                    r_opa <= (r_op == OP_LP) ? diff_lp : diff_hp;
                end
                S_WB: begin
                    case (r_op)
                        OP_HP: begin
                            r_op <= OP_LP;
                        end
                        OP_LP: begin
                            if (gain_kind(r_band) == GK_LIN) begin
                                r_gain <= gain_lin;
                                r_op   <= OP_TERM;
                            end else begin
                                r_op <= OP_KSQ;
                            end
                        end
                        OP_KSQ: begin
                            r_ksq <= prod[31:0];
                            case (gain_kind(r_band))
                                GK_ENV: begin
                                    r_op <= OP_KPLB;
                                end
                                GK_SQ7: begin
                                    r_gain <= signed'(rnd7[OPB_W-1:0]) - HALF_GAIN;
                                    r_op   <= OP_TERM;
                                end
                                GK_SQ5: begin
                                    r_gain <= signed'(rnd5[OPB_W-1:0]);
                                    r_op   <= OP_TERM;
                                end
                                default: begin
                                    r_gain <= gain_lin;
                                    r_op   <= OP_TERM;
                                end
                            endcase
                        end
                        OP_KPLB: begin
                            r_gain <= signed'(rnd32[OPB_W-1:0]) - HALF_GAIN;
                            r_op   <= OP_TERM;
                        end
                        OP_TERM: begin
                            r_acc <= r_acc + signed'(rnd24[ACC_W-1:0]);
                            if (r_band != LAST_BAND) begin
                                r_band <= r_band + 1'b1;
                            end
                            r_op <= OP_HP;
                        end
                        default: r_op <= OP_HP;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/sbeq_cfg_regs.sv =====
// configuration registers of the tone eq and their unpacking into band fields
// depends on sbeq_pkg
module sbeq_cfg_regs
    import sbeq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [63:0]       r_knob_lo;
    logic [31:0]       r_knob_hi;
    logic [63:0]       r_coef_a;
    logic [63:0]       r_coef_b;
    logic [63:0]       r_coef_c;
    logic [STEP_W-1:0] r_attack;
    logic [STEP_W-1:0] r_release;

    logic [95:0]  knob_all;
    logic [191:0] coef_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob_lo <= 64'h0000_7FFF_8000_0000;
            r_knob_hi <= '0;
            r_coef_a  <= '0;
            r_coef_b  <= '0;
            r_coef_c  <= '0;
            r_attack  <= 24'd22370;
            r_release <= 24'd5592;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KNOB_LO: r_knob_lo <= i_cfg_data;
                REG_KNOB_HI: r_knob_hi <= i_cfg_data[31:0];
                REG_COEF_A:  r_coef_a  <= i_cfg_data;
                REG_COEF_B:  r_coef_b  <= i_cfg_data;
                REG_COEF_C:  r_coef_c  <= i_cfg_data;
                REG_ATTACK:  r_attack  <= i_cfg_data[STEP_W-1:0];
                REG_RELEASE: r_release <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient n: high-pass 0..5 then low-pass 0..5, in 16-bit slots
    assign knob_all = {r_knob_hi, r_knob_lo};
    assign coef_all = {r_coef_c, r_coef_b, r_coef_a};

    always_comb begin
        for (int k = 0; k < BANDS; k++) begin
            o_cfg.knob[k]    = knob_all[KNOB_W*k +: KNOB_W];
            o_cfg.hp_coef[k] = coef_all[KNOB_W*k +: KNOB_W];
            o_cfg.lp_coef[k] = coef_all[KNOB_W*(k+BANDS) +: KNOB_W];
        end
        o_cfg.atk_step = r_attack;
        o_cfg.rel_step = r_release;
    end

endmodule

// ===== rtl/sbeq_mul.sv =====
// shared signed multiplier with a registered product
// depends on sbeq_pkg
module sbeq_mul
    import sbeq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [OPA_W-1:0]  i_a,
    input  logic signed [OPB_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/sbeq_env.sv =====
// envelope follower: attack compare, then release compare, then clamp to [0,1]
// depends on sbeq_pkg
module sbeq_env
    import sbeq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_env_ctl                i_ctl,
    input  logic signed [X_W-1:0]   i_x,
    input  logic [STEP_W-1:0]       i_atk,
    input  logic [STEP_W-1:0]       i_rel,
    output logic [ENV_W-1:0]        o_env
);

    logic [ENV_W-1:0]  r_env;
    logic signed [26:0] r_tmp;

    logic signed [26:0] mag;
    logic signed [26:0] env_s;
    logic signed [26:0] atk_s;
    logic signed [26:0] rel_s;
    logic signed [26:0] fall;
    logic signed [26:0] one_s;

    always_comb begin
        mag   = (i_x < 0) ? -27'(i_x) : 27'(i_x);
        env_s = signed'({2'b00, r_env});
        atk_s = signed'({3'b000, i_atk});
        rel_s = signed'({3'b000, i_rel});
        one_s = signed'({2'b00, ONE_Q24});
        fall  = (mag < r_tmp) ? (r_tmp - rel_s) : r_tmp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (i_ctl.step_b) begin
            if (fall < 0) begin
                r_env <= '0;
            end else if (fall > one_s) begin
                r_env <= ONE_Q24;
            end else begin
                r_env <= fall[ENV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step_a) begin
            r_tmp <= (mag > env_s) ? (env_s + atk_s) : env_s;
        end
    end

    assign o_env = r_env;

endmodule
